FILE: rtl/core/cfcs_pkg.sv
package cfcs_pkg;

    localparam int MAX_QUBITS = 64;

    typedef logic [MAX_QUBITS-1:0] t_word;

    // Request codes
    localparam logic [3:0] REQ_H     = 4'd0;
    localparam logic [3:0] REQ_S     = 4'd1;
    localparam logic [3:0] REQ_SDAG  = 4'd2;
    localparam logic [3:0] REQ_X     = 4'd3;
    localparam logic [3:0] REQ_Y     = 4'd4;
    localparam logic [3:0] REQ_Z     = 4'd5;
    localparam logic [3:0] REQ_CX    = 4'd6;
    localparam logic [3:0] REQ_CZ    = 4'd7;
    localparam logic [3:0] REQ_SWAP  = 4'd8;
    localparam logic [3:0] REQ_QUERY = 4'd9;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_QUBIT = 2'd1;
    localparam logic [1:0] ST_BAD_BASIS = 2'd2;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [5:0]  first_qubit;
        logic [5:0]  second_qubit;
        logic [63:0] basis_query;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic              amp_zero;
        logic [2:0]        amp_phase_eighths;
        logic signed [7:0] amp_root2_exponent;
    } t_rsp;

    // One row of the tableau: G, F, M bits and the qubit phase
    typedef struct packed {
        t_word      g;
        t_word      f;
        t_word      m;
        logic [1:0] ph;
    } t_row;

    // Micro-operations that a request is broken into
    typedef enum logic [2:0] {
        UOP_ROW1,
        UOP_CX,
        UOP_CZ,
        UOP_H,
        UOP_QUERY,
        UOP_SCALE
    } t_uop_kind;

    typedef struct packed {
        t_uop_kind  kind;
        logic       swap;
        logic [1:0] ph_add;
        logic       m_flip;
        logic       last;
    } t_uop;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LOAD,
        ACT_ROW1,
        ACT_LATCH,
        ACT_PAIR1,
        ACT_PAIR2,
        ACT_HCALC,
        ACT_HPIV,
        ACT_HSPLIT,
        ACT_HROW,
        ACT_QINIT,
        ACT_QROW,
        ACT_QDONE,
        ACT_SCALE2,
        ACT_PUBLISH
    } t_act;

    typedef struct packed {
        t_act       act;
        logic [5:0] addr;
        logic [5:0] rd_addr;
        logic [1:0] ph_add;
        logic       m_flip;
        logic       pair_cz;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_status;
        logic       h_equal;
        logic [5:0] last_row;
    } t_sts;

    function automatic t_uop mk_uop(input t_uop_kind kind, input logic swap,
                                    input logic [1:0] ph_add, input logic m_flip,
                                    input logic last);
        t_uop u;
        u.kind   = kind;
        u.swap   = swap;
        u.ph_add = ph_add;
        u.m_flip = m_flip;
        u.last   = last;
        return u;
    endfunction

    // Micro-operation sequence of each request
    function automatic t_uop uop_of(input logic [3:0] kind, input logic [2:0] step);
        t_uop u;
        t_uop z_row;
        z_row = mk_uop(UOP_ROW1, 1'b0, 2'd2, 1'b0, 1'b0);
        u = mk_uop(UOP_SCALE, 1'b0, 2'd0, 1'b0, 1'b1);
        case (kind)
            REQ_H:    u = mk_uop(UOP_H, 1'b0, 2'd0, 1'b0, 1'b1);
            REQ_S:    u = mk_uop(UOP_ROW1, 1'b0, 2'd3, 1'b1, 1'b1);
            REQ_SDAG: u = mk_uop(UOP_ROW1, 1'b0, 2'd1, 1'b1, 1'b1);
            REQ_Z:    u = mk_uop(UOP_ROW1, 1'b0, 2'd2, 1'b0, 1'b1);
            REQ_X: begin
                case (step)
                    3'd0:    u = mk_uop(UOP_H, 1'b0, 2'd0, 1'b0, 1'b0);
                    3'd1:    u = z_row;
                    default: u = mk_uop(UOP_H, 1'b0, 2'd0, 1'b0, 1'b1);
                endcase
            end
            REQ_Y: begin
                case (step)
                    3'd0:    u = z_row;
                    3'd1:    u = mk_uop(UOP_H, 1'b0, 2'd0, 1'b0, 1'b0);
                    3'd2:    u = z_row;
                    3'd3:    u = mk_uop(UOP_H, 1'b0, 2'd0, 1'b0, 1'b0);
                    default: u = mk_uop(UOP_SCALE, 1'b0, 2'd0, 1'b0, 1'b1);
                endcase
            end
            REQ_CX:   u = mk_uop(UOP_CX, 1'b0, 2'd0, 1'b0, 1'b1);
            REQ_CZ:   u = mk_uop(UOP_CZ, 1'b0, 2'd0, 1'b0, 1'b1);
            REQ_SWAP: begin
                case (step)
                    3'd0:    u = mk_uop(UOP_CX, 1'b0, 2'd0, 1'b0, 1'b0);
                    3'd1:    u = mk_uop(UOP_CX, 1'b1, 2'd0, 1'b0, 1'b0);
                    default: u = mk_uop(UOP_CX, 1'b0, 2'd0, 1'b0, 1'b1);
                endcase
            end
            REQ_QUERY: u = mk_uop(UOP_QUERY, 1'b0, 2'd0, 1'b0, 1'b1);
            default:   u = mk_uop(UOP_SCALE, 1'b0, 2'd0, 1'b0, 1'b1);
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/cfcs_ctrl.sv
module cfcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_stall,
    output logic            o_valid,
    input  cfcs_pkg::t_req  i_req,
    input  cfcs_pkg::t_sts  i_sts,
    output cfcs_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_ROW1,
        S_PRD2,
        S_PW1,
        S_PW2,
        S_HCALC,
        S_HPIV,
        S_HSPLIT,
        S_HSW,
        S_QROW,
        S_QEND,
        S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [2:0] r_step, n_step;
    logic [3:0] r_kind, n_kind;
    logic [5:0] r_qa, n_qa;
    logic [5:0] r_qb, n_qb;
    logic       r_out_valid, n_out_valid;

    cfcs_pkg::t_uop uop;
    logic [5:0]     first_q;
    logic [5:0]     second_q;
    logic           adv;
    logic           publish;

    assign uop      = cfcs_pkg::uop_of(r_kind, r_step);
    assign first_q  = uop.swap ? r_qb : r_qa;
    assign second_q = uop.swap ? r_qa : r_qb;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign publish  = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // Sequence the micro-operations of the current transaction
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_step  = r_step;
        n_kind  = r_kind;
        n_qa    = r_qa;
        n_qb    = r_qb;
        adv     = 1'b0;
        o_cmd.act     = cfcs_pkg::ACT_NONE;
        o_cmd.addr    = first_q;
        o_cmd.rd_addr = first_q;
        o_cmd.ph_add  = uop.ph_add;
        o_cmd.m_flip  = uop.m_flip;
        o_cmd.pair_cz = (uop.kind == cfcs_pkg::UOP_CZ);

        case (r_state)
            S_CLEAR: begin
                o_cmd.act  = cfcs_pkg::ACT_CLEAR;
                o_cmd.addr = r_cnt;
                if (r_cnt == 6'(cfcs_pkg::MAX_QUBITS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.act = cfcs_pkg::ACT_LOAD;
                    n_kind    = i_req.req_type;
                    n_qa      = i_req.first_qubit;
                    n_qb      = i_req.second_qubit;
                    n_step    = '0;
                    if (i_sts.req_status != cfcs_pkg::ST_OK ||
                        i_req.req_type > cfcs_pkg::REQ_QUERY) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_DISPATCH;
                    end
                end
            end
            S_DISPATCH: begin
                case (uop.kind)
                    cfcs_pkg::UOP_ROW1:  n_state = S_ROW1;
                    cfcs_pkg::UOP_CX:    n_state = S_PRD2;
                    cfcs_pkg::UOP_CZ:    n_state = S_PRD2;
                    cfcs_pkg::UOP_H:     n_state = S_HCALC;
                    cfcs_pkg::UOP_QUERY: begin
                        o_cmd.act     = cfcs_pkg::ACT_QINIT;
                        o_cmd.rd_addr = '0;
                        n_cnt         = '0;
                        n_state       = S_QROW;
                    end
                    default: begin
                        o_cmd.act = cfcs_pkg::ACT_SCALE2;
                        adv       = 1'b1;
                    end
                endcase
            end
            S_ROW1: begin
                o_cmd.act = cfcs_pkg::ACT_ROW1;
                adv       = 1'b1;
            end
            S_PRD2: begin
                o_cmd.act     = cfcs_pkg::ACT_LATCH;
                o_cmd.rd_addr = second_q;
                n_state       = S_PW1;
            end
            S_PW1: begin
                o_cmd.act  = cfcs_pkg::ACT_PAIR1;
                o_cmd.addr = second_q;
                n_state    = S_PW2;
            end
            S_PW2: begin
                o_cmd.act = cfcs_pkg::ACT_PAIR2;
                adv       = 1'b1;
            end
            S_HCALC: begin
                o_cmd.act = cfcs_pkg::ACT_HCALC;
                n_state   = S_HPIV;
            end
            S_HPIV: begin
                o_cmd.act = cfcs_pkg::ACT_HPIV;
                if (i_sts.h_equal) begin
                    adv = 1'b1;
                end else begin
                    n_state = S_HSPLIT;
                end
            end
            S_HSPLIT: begin
                o_cmd.act     = cfcs_pkg::ACT_HSPLIT;
                o_cmd.rd_addr = '0;
                n_cnt         = '0;
                n_state       = S_HSW;
            end
            S_HSW: begin
                o_cmd.act     = cfcs_pkg::ACT_HROW;
                o_cmd.addr    = r_cnt;
                o_cmd.rd_addr = r_cnt + 6'd1;
                if (r_cnt == i_sts.last_row) begin
                    adv = 1'b1;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_QROW: begin
                o_cmd.act     = cfcs_pkg::ACT_QROW;
                o_cmd.addr    = r_cnt;
                o_cmd.rd_addr = r_cnt + 6'd1;
                if (r_cnt == i_sts.last_row) begin
                    n_state = S_QEND;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_QEND: begin
                o_cmd.act = cfcs_pkg::ACT_QDONE;
                adv       = 1'b1;
            end
            S_DONE: begin
                if (publish) begin
                    o_cmd.act = cfcs_pkg::ACT_PUBLISH;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Advance to the next micro-operation or finish
        if (adv) begin
            if (uop.last) begin
                n_state = S_DONE;
            end else begin
                n_step  = r_step + 3'd1;
                n_state = S_DISPATCH;
            end
        end

        // Hold the result flag until the transaction is taken
        if (publish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_step      <= '0;
            r_kind      <= '0;
            r_qa        <= '0;
            r_qb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_kind      <= n_kind;
            r_qa        <= n_qa;
            r_qb        <= n_qb;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: rtl/core/cfcs_dpath.sv
module cfcs_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cfcs_pkg::t_cmd  i_cmd,
    input  cfcs_pkg::t_req  i_req,
    input  logic [6:0]      i_qubits,
    output cfcs_pkg::t_sts  o_sts,
    output cfcs_pkg::t_rsp  o_rsp
);

    typedef struct packed {
        logic       new_bit;
        logic       need_s;
        logic       keep_h;
        logic [2:0] ph8;
    } t_split;

    // Split the pivot sum |y> + i^d |z>
    function automatic t_split split_h(input logic hbit, input logic ybit,
                                       input logic [1:0] d);
        t_split     s;
        logic [1:0] adj;
        s   = '0;
        adj = ybit ? (2'd0 - d) : d;
        if (!hbit) begin
            s.ph8     = ybit ? {d, 1'b0} : 3'd0;
            s.new_bit = adj[1];
            s.need_s  = adj[0];
            s.keep_h  = 1'b1;
        end else if (!d[0]) begin
            s.new_bit = d[1];
            s.ph8     = (d[1] && ybit) ? 3'd4 : 3'd0;
        end else begin
            s.ph8     = (d == 2'd1) ? 3'd1 : 3'd7;
            s.need_s  = 1'b1;
            s.keep_h  = 1'b1;
            s.new_bit = !(d[1] ^ ybit);
        end
        return s;
    endfunction

    function automatic logic [5:0] low_index(input cfcs_pkg::t_word x);
        logic [5:0] k;
        k = '0;
        for (int i = cfcs_pkg::MAX_QUBITS - 1; i >= 0; i--) begin
            if (x[i]) k = 6'(i);
        end
        return k;
    endfunction

    cfcs_pkg::t_row  mem [cfcs_pkg::MAX_QUBITS];
    cfcs_pkg::t_row  r_rd;
    cfcs_pkg::t_row  r_ra;

    // Architectural state
    cfcs_pkg::t_word   r_hmask, n_hmask;
    cfcs_pkg::t_word   r_basis, n_basis;
    logic              r_zero, n_zero;
    logic [2:0]        r_sphase, n_sphase;
    logic signed [7:0] r_sexp, n_sexp;

    // Working registers
    cfcs_pkg::t_word   r_bq, r_va, r_vb, r_zset, r_oset, r_zp, r_om, r_vec;
    logic [1:0]        r_d, r_acc;
    logic              r_neg, r_eq, r_zany, r_need_s;
    logic [5:0]        r_piv;
    logic [6:0]        r_cnt;
    logic [1:0]        r_status;
    logic              r_az;
    logic [2:0]        r_aph;
    logic signed [7:0] r_aex;
    cfcs_pkg::t_rsp    r_rsp;

    cfcs_pkg::t_word live;
    cfcs_pkg::t_word pbit;
    logic            qa_bad, qb_bad;
    logic [1:0]      req_status;

    assign live  = (i_qubits >= 7'(cfcs_pkg::MAX_QUBITS)) ? '1
                 : ((cfcs_pkg::t_word'(1) << i_qubits) - cfcs_pkg::t_word'(1));
    assign pbit  = cfcs_pkg::t_word'(1) << r_piv;
    assign o_rsp = r_rsp;

    // Check the request as it arrives
    always_comb begin
        qa_bad = ({1'b0, i_req.first_qubit} >= i_qubits);
        qb_bad = ({1'b0, i_req.second_qubit} >= i_qubits);
        req_status = cfcs_pkg::ST_OK;
        if (i_req.req_type <= cfcs_pkg::REQ_Z) begin
            if (qa_bad) req_status = cfcs_pkg::ST_BAD_QUBIT;
        end else if (i_req.req_type <= cfcs_pkg::REQ_SWAP) begin
            if (qa_bad || qb_bad || i_req.first_qubit == i_req.second_qubit)
                req_status = cfcs_pkg::ST_BAD_QUBIT;
        end else if (i_req.req_type == cfcs_pkg::REQ_QUERY) begin
            if ((i_req.basis_query & ~live) != '0) req_status = cfcs_pkg::ST_BAD_BASIS;
        end
    end

    assign o_sts.req_status = req_status;
    assign o_sts.h_equal    = r_eq;
    assign o_sts.last_row   = 6'(i_qubits - 7'd1);

    // Single-row update for S, S-dagger and Z
    cfcs_pkg::t_row row1;
    always_comb begin
        row1 = r_rd;
        if (i_cmd.m_flip) row1.m = r_rd.m ^ r_rd.g;
        row1.ph = r_rd.ph + i_cmd.ph_add;
    end

    // Two-row update for CX and CZ: first row in r_ra, second in r_rd
    cfcs_pkg::t_row pc_new, pt_new;
    logic           pair_par;
    always_comb begin
        pc_new   = r_ra;
        pt_new   = r_rd;
        pair_par = ^(r_ra.m & r_rd.f & live);
        if (i_cmd.pair_cz) begin
            pc_new.m = r_ra.m ^ r_rd.g;
            pt_new.m = r_rd.m ^ r_ra.g;
        end else begin
            pc_new.ph = r_ra.ph + r_rd.ph + {pair_par, 1'b0};
            pt_new.g  = r_rd.g ^ r_ra.g;
            pc_new.f  = r_ra.f ^ r_rd.f;
            pc_new.m  = r_ra.m ^ r_rd.m;
        end
    end

    // H preparation from the target row
    cfcs_pkg::t_word h_gr, h_fr, h_mr, h_va, h_vb;
    logic            h_neg, h_bet;
    logic [1:0]      h_d;
    always_comb begin
        h_gr  = r_rd.g & live;
        h_fr  = r_rd.f & live;
        h_mr  = r_rd.m & live;
        h_va  = (r_basis ^ (h_gr & r_hmask)) & live;
        h_vb  = (r_basis ^ ((h_fr & ~r_hmask) ^ (h_mr & r_hmask))) & live;
        h_neg = ^(h_gr & ~r_hmask & r_basis);
        h_bet = (^(h_mr & ~r_hmask & r_basis)) ^ (^(h_fr & r_hmask & h_mr))
              ^ (^(h_fr & r_hmask & r_basis));
        h_d   = r_rd.ph + {h_neg ^ h_bet, 1'b0};
    end

    // Pivot choice
    cfcs_pkg::t_word pv_diff, pv_zset, pv_oset;
    logic            pv_zany;
    logic [5:0]      pv_piv;
    always_comb begin
        pv_diff = r_va ^ r_vb;
        pv_zset = pv_diff & ~r_hmask;
        pv_oset = pv_diff & r_hmask;
        pv_zany = (pv_zset != '0);
        pv_piv  = low_index(pv_zany ? pv_zset : pv_oset);
    end

    // Pivot split
    cfcs_pkg::t_word sp_vy;
    t_split          sp;
    always_comb begin
        sp_vy = r_va[r_piv] ? (r_vb ^ pbit) : r_va;
        sp    = split_h(r_hmask[r_piv], sp_vy[r_piv], r_d);
    end

    // Column sweep applied to one row
    cfcs_pkg::t_row hrow;
    logic           hr_fp, hr_fo;
    always_comb begin
        hrow  = r_rd;
        hr_fp = r_rd.f[r_piv];
        hr_fo = ^(r_rd.f & r_om);
        if (r_zany) begin
            hrow.g  = r_rd.g ^ ((^(r_rd.g & r_zp)) ? pbit : '0);
            hrow.f  = r_rd.f ^ (hr_fp ? r_zp : '0);
            hrow.m  = r_rd.m ^ (((^(r_rd.m & r_zp)) ^ hr_fo) ? pbit : '0)
                    ^ (hr_fp ? r_om : '0);
            hrow.ph = r_rd.ph + {hr_fp & hr_fo, 1'b0};
        end else begin
            hrow.g = r_rd.g ^ (r_rd.g[r_piv] ? r_om : '0);
            hrow.f = r_rd.f ^ (hr_fo ? pbit : '0);
            hrow.m = r_rd.m ^ (r_rd.m[r_piv] ? r_om : '0);
        end
        if (r_need_s && hrow.f[r_piv]) begin
            hrow.m  = hrow.m ^ pbit;
            hrow.ph = hrow.ph + 2'd3;
        end
    end

    // Query accumulation and final amplitude
    cfcs_pkg::t_word   q_vec, q_vecl;
    logic [1:0]        q_acc;
    logic              q_az, q_sg;
    logic signed [8:0] q_ex;
    always_comb begin
        q_vec = r_vec ^ r_rd.f;
        q_acc = r_acc + r_rd.ph + {(^(r_rd.m & q_vec & live)), 1'b0};
        q_vecl = r_vec & live;
        q_az  = r_zero || ((~r_hmask & (q_vecl ^ r_basis) & live) != '0);
        q_sg  = ^(r_hmask & q_vecl & r_basis);
        q_ex  = $signed({r_sexp[7], r_sexp}) - $signed({2'b00, r_cnt});
    end

    // Scalar and global state updates
    logic [2:0] sc_ph8;
    logic       sc_r2, sc_en;
    always_comb begin
        n_hmask  = r_hmask;
        n_basis  = r_basis;
        n_zero   = r_zero;
        n_sphase = r_sphase;
        n_sexp   = r_sexp;
        sc_ph8   = '0;
        sc_r2    = 1'b0;
        sc_en    = 1'b0;
        case (i_cmd.act)
            cfcs_pkg::ACT_HPIV: begin
                if (r_eq) begin
                    n_basis = r_va;
                    if (r_d == 2'd2) begin
                        n_zero = 1'b1;
                    end else if (r_d == 2'd0) begin
                        sc_en  = 1'b1;
                        sc_ph8 = r_neg ? 3'd4 : 3'd0;
                        sc_r2  = 1'b1;
                    end else begin
                        sc_en  = 1'b1;
                        sc_ph8 = ((r_d == 2'd1) ? 3'd1 : 3'd7) + (r_neg ? 3'd4 : 3'd0);
                    end
                end
            end
            cfcs_pkg::ACT_HSPLIT: begin
                n_basis = sp.new_bit ? (sp_vy | pbit) : (sp_vy & ~pbit);
                n_hmask = sp.keep_h ? (r_hmask | pbit) : (r_hmask & ~pbit);
                sc_en   = 1'b1;
                sc_ph8  = sp.ph8 + (r_neg ? 3'd4 : 3'd0);
            end
            cfcs_pkg::ACT_SCALE2: begin
                sc_en  = 1'b1;
                sc_ph8 = 3'd2;
            end
            default: ;
        endcase
        if (sc_en && !r_zero) begin
            n_sphase = r_sphase + sc_ph8;
            if (sc_r2 && r_sexp != 8'sd127) n_sexp = r_sexp + 8'sd1;
        end
    end

    // Memory write select
    logic           wr_en;
    cfcs_pkg::t_row wdata;
    always_comb begin
        wr_en = 1'b1;
        wdata = r_rd;
        case (i_cmd.act)
            cfcs_pkg::ACT_CLEAR: begin
                wdata.g  = cfcs_pkg::t_word'(1) << i_cmd.addr;
                wdata.f  = cfcs_pkg::t_word'(1) << i_cmd.addr;
                wdata.m  = '0;
                wdata.ph = '0;
            end
            cfcs_pkg::ACT_ROW1:  wdata = row1;
            cfcs_pkg::ACT_PAIR1: wdata = pt_new;
            cfcs_pkg::ACT_PAIR2: wdata = r_ra;
            cfcs_pkg::ACT_HROW:  wdata = hrow;
            default:             wr_en = 1'b0;
        endcase
    end

    // Row store: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[i_cmd.addr] <= wdata;
        r_rd <= mem[i_cmd.rd_addr];
    end

    // Hold the global state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hmask  <= '0;
            r_basis  <= '0;
            r_zero   <= 1'b0;
            r_sphase <= '0;
            r_sexp   <= '0;
        end else begin
            r_hmask  <= n_hmask;
            r_basis  <= n_basis;
            r_zero   <= n_zero;
            r_sphase <= n_sphase;
            r_sexp   <= n_sexp;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            cfcs_pkg::ACT_LOAD: begin
                r_bq     <= i_req.basis_query;
                r_status <= req_status;
                r_az     <= 1'b0;
                r_aph    <= '0;
                r_aex    <= '0;
            end
            cfcs_pkg::ACT_LATCH: r_ra <= r_rd;
            cfcs_pkg::ACT_PAIR1: r_ra <= pc_new;
            cfcs_pkg::ACT_HCALC: begin
                r_va  <= h_va;
                r_vb  <= h_vb;
                r_d   <= h_d;
                r_neg <= h_neg;
                r_eq  <= (h_va == h_vb);
            end
            cfcs_pkg::ACT_HPIV: begin
                r_zset <= pv_zset;
                r_oset <= pv_oset;
                r_zany <= pv_zany;
                r_piv  <= pv_piv;
            end
            cfcs_pkg::ACT_HSPLIT: begin
                r_zp     <= r_zset & ~pbit;
                r_om     <= r_zany ? r_oset : (r_oset & ~pbit);
                r_need_s <= sp.need_s;
            end
            cfcs_pkg::ACT_QINIT: begin
                r_acc <= '0;
                r_vec <= '0;
                r_cnt <= '0;
            end
            cfcs_pkg::ACT_QROW: begin
                r_cnt <= r_cnt + {6'd0, r_hmask[i_cmd.addr]};
                if (r_bq[i_cmd.addr]) begin
                    r_acc <= q_acc;
                    r_vec <= q_vec;
                end
            end
            cfcs_pkg::ACT_QDONE: begin
                r_az <= q_az;
                if (q_az) begin
                    r_aph <= '0;
                    r_aex <= '0;
                end else begin
                    r_aph <= r_sphase + {r_acc, 1'b0} + {q_sg, 2'b00};
                    r_aex <= (q_ex < -9'sd128) ? -8'sd128 : 8'(q_ex);
                end
            end
            cfcs_pkg::ACT_PUBLISH: begin
                r_rsp.status             <= r_status;
                r_rsp.amp_zero           <= r_az;
                r_rsp.amp_phase_eighths  <= r_aph;
                r_rsp.amp_root2_exponent <= r_aex;
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/ch_form_clifford_simulator.sv
// CH-form stabilizer simulator for up to 64 qubits. Each transaction is one
// gate or one amplitude query and gives exactly one result transaction; one
// transaction is worked on at a time, while the previous result may still
// wait in the output register. The tableau rows live in a single-port-write,
// registered-read row store, so cost is set by sweeps over that store: H,
// X and Y sweep the qubits_in_use rows when a column sweep is needed, and a
// query always does. Requests with a bad qubit or stray basis bits, and
// unknown request codes, go straight to the result. After reset a pass over
// all 64 rows loads the identity tableau, during which o_stall is high.
// qubits_in_use is written over the APB port at any address with paddr[2]
// clear and is clamped to 1..64; write it only while the block is idle.
module ch_form_clifford_simulator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cfcs_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output cfcs_pkg::t_rsp  o_rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [6:0]     r_qubits;
    logic [6:0]     wr_val;
    cfcs_pkg::t_cmd cmd;
    cfcs_pkg::t_sts sts;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_qubits};

    // Clamp the written qubit count to the built range
    always_comb begin
        wr_val = pwdata[6:0];
        if (wr_val == 7'd0) wr_val = 7'd1;
        if (wr_val > 7'(cfcs_pkg::MAX_QUBITS)) wr_val = 7'(cfcs_pkg::MAX_QUBITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qubits <= 7'(cfcs_pkg::MAX_QUBITS);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_qubits <= wr_val;
        end
    end

    cfcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfcs_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .i_qubits (r_qubits),
        .o_sts    (sts),
        .o_rsp    (o_rsp)
    );

endmodule

FILE: rtl/core/cfcs_checker.sv
module cfcs_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_stall,
    input  logic            o_valid,
    input  logic            i_stall,
    input  cfcs_pkg::t_rsp  o_rsp
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // Drop amplitude fields on any error status
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != cfcs_pkg::ST_OK |->
            !o_rsp.amp_zero && o_rsp.amp_phase_eighths == 3'd0 &&
            o_rsp.amp_root2_exponent == 8'sd0)
        else $error("error result carries amplitude fields");

    // Zero amplitude carries no phase or exponent
    a_zero_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.amp_zero |->
            o_rsp.amp_phase_eighths == 3'd0 && o_rsp.amp_root2_exponent == 8'sd0)
        else $error("zero amplitude with phase or exponent");

    // Stall input and show no result straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("block not held after reset");

endmodule

bind ch_form_clifford_simulator cfcs_checker u_cfcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
